[hw/rtl/gha_pkg.sv]
// Shared types and constants for the generational handle allocator.
// No dependencies; every other file uses these by scoped names.
`timescale 1ns / 1ps

package gha_pkg;

  localparam int MAX_BLOCKS_DEFAULT = 1024;

  localparam int HANDLE_W = 32;
  localparam int IDX_W    = 16;
  localparam int GEN_W    = 16;
  localparam int CNT_W    = 11;
  localparam int SIDX_W   = 10;
  localparam int OP_W     = 2;

  localparam logic [CNT_W-1:0] POOL_SIZE_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_LOOKUP = 2'd2
  } opcode_t;

  // Controller to datapath.
  typedef struct packed {
    logic accept;     // request beat taken, launch table reads
    logic exec;       // apply the operation and load the result register
    logic cfg_write;  // new pool size, reinitialize the pool
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_stall;  // result register full and not drained this cycle
  } sts_t;

  // One slot table entry.
  typedef struct packed {
    logic             free;
    logic [GEN_W-1:0] gen;
  } slot_t;

endpackage

[hw/rtl/gha_req_if.sv]
// Request channel: opcode and handle, valid/ready handshake.
// Depends on gha_pkg for field widths.
`timescale 1ns / 1ps

interface gha_req_if;
  logic                          valid;
  logic                          ready;
  logic [gha_pkg::OP_W-1:0]      opcode;
  logic [gha_pkg::HANDLE_W-1:0]  handle_in;

  modport source (output valid, opcode, handle_in, input ready);
  modport sink   (input valid, opcode, handle_in, output ready);
endinterface

[hw/rtl/gha_rsp_if.sv]
// Response channel: status, new handle, slot index, live count.
// Depends on gha_pkg for field widths.
`timescale 1ns / 1ps

interface gha_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [gha_pkg::HANDLE_W-1:0]  handle_out;
  logic [gha_pkg::SIDX_W-1:0]    slot_index;
  logic [gha_pkg::CNT_W-1:0]     live_count;

  modport source (output valid, status, handle_out, slot_index, live_count, input ready);
  modport sink   (input valid, status, handle_out, slot_index, live_count, output ready);
endinterface

[hw/rtl/gha_cfg_if.sv]
// Configuration write channel carrying the pool size.
// Depends on gha_pkg for the field width.
`timescale 1ns / 1ps

interface gha_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [gha_pkg::CNT_W-1:0]   pool_size;

  modport source (output valid, pool_size, input ready);
  modport sink   (input valid, pool_size, output ready);
endinterface

[hw/rtl/gha_ctrl.sv]
// Two-state sequencer: take a request beat, then execute it once the
// result register can be loaded. Depends on gha_pkg.
`timescale 1ns / 1ps

module gha_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          cfg_valid,
  input  gha_pkg::sts_t sts,
  output logic          req_ready,
  output logic          cfg_ready,
  output gha_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration wins over a request in the same cycle.
  assign cfg_ready     = (state == ST_IDLE);
  assign req_ready     = (state == ST_IDLE) && !cfg_valid;
  assign cmd.accept    = req_valid && req_ready;
  assign cmd.cfg_write = cfg_valid && cfg_ready;
  assign cmd.exec      = (state == ST_EXEC) && !sts.out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd.exec) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == ST_EXEC) && !req_ready)
    else $error("request beat did not move the sequencer to execute");

  a_no_cfg_in_exec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> !cmd.cfg_write && !cmd.accept)
    else $error("config or request taken while an operation is in flight");

endmodule

[hw/rtl/gha_datapath.sv]
// Slot tables, free-list registers and result register of the allocator.
// Depends on gha_pkg; commanded by gha_ctrl.
`timescale 1ns / 1ps

module gha_datapath #(
  parameter int MAX_BLOCKS = gha_pkg::MAX_BLOCKS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gha_pkg::cmd_t                 cmd,
  output gha_pkg::sts_t                 sts,
  input  logic [gha_pkg::OP_W-1:0]      req_opcode,
  input  logic [gha_pkg::HANDLE_W-1:0]  req_handle_in,
  input  logic [gha_pkg::CNT_W-1:0]     cfg_pool_size,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic                          rsp_status,
  output logic [gha_pkg::HANDLE_W-1:0]  rsp_handle_out,
  output logic [gha_pkg::SIDX_W-1:0]    rsp_slot_index,
  output logic [gha_pkg::CNT_W-1:0]     rsp_live_count
);

  localparam int IW   = $clog2(MAX_BLOCKS);
  localparam int PW   = (IW > gha_pkg::CNT_W) ? IW : gha_pkg::CNT_W;
  localparam int MW   = gha_pkg::IDX_W + 1;
  localparam int CW   = gha_pkg::CNT_W;
  localparam int GW   = gha_pkg::GEN_W;
  localparam int XW   = gha_pkg::IDX_W;
  localparam logic [MW-1:0] MAX_W = MW'(MAX_BLOCKS);

  // Slot state memory and free-list link memory. Entries at or above
  // fresh_next were never handed out and read as free with generation 0,
  // so neither memory needs clearing.
  gha_pkg::slot_t slot_mem [MAX_BLOCKS];
  logic [IW-1:0]  link_mem [MAX_BLOCKS];

  logic [CW-1:0]  pool_size;
  logic [CW-1:0]  fresh_next;
  logic [CW-1:0]  allocated_total;
  logic [IW-1:0]  recycled_head;
  logic           recycled_valid;

  logic [gha_pkg::OP_W-1:0]      op_q;
  logic [gha_pkg::HANDLE_W-1:0]  handle_q;
  gha_pkg::slot_t                st_rd;
  logic [IW-1:0]                 link_rd;
  logic [IW-1:0]                 rd_addr;

  // Execute-cycle decode
  logic [CW-1:0]  n_cnt;
  logic [XW-1:0]  idx;
  logic [GW-1:0]  hgen;
  logic           in_range;
  logic           seen;
  logic           eff_free;
  logic [CW-1:0]  remaining;
  logic [PW-1:0]  fresh_ext;
  logic [IW-1:0]  fresh_slot;
  logic           have;
  logic [IW-1:0]  slot;
  logic [GW-1:0]  cur_gen;
  logic [GW-1:0]  new_gen;
  logic           free_ok;
  logic           look_ok;
  logic [31:0]    slot_ext;
  logic [31:0]    idx_ext;

  logic                          st_we;
  logic [IW-1:0]                 st_waddr;
  gha_pkg::slot_t                st_wdata;
  logic                          link_we;

  logic [CW-1:0]  fresh_next_next;
  logic [CW-1:0]  allocated_total_next;
  logic [IW-1:0]  recycled_head_next;
  logic           recycled_valid_next;
  logic                          status_next;
  logic [gha_pkg::HANDLE_W-1:0]  handle_out_next;
  logic [gha_pkg::SIDX_W-1:0]    slot_index_next;

  assign sts.out_stall = rsp_valid && !rsp_ready;

  assign rd_addr = (req_opcode == gha_pkg::OP_ALLOC) ? recycled_head
                                                     : req_handle_in[IW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q     <= req_opcode;
      handle_q <= req_handle_in;
      st_rd    <= slot_mem[rd_addr];
      link_rd  <= link_mem[recycled_head];
    end
    if (st_we) slot_mem[st_waddr] <= st_wdata;
    if (link_we) link_mem[idx[IW-1:0]] <= recycled_head;
  end

  always_comb begin
    n_cnt      = (MW'(pool_size) > MAX_W) ? MAX_W[CW-1:0] : pool_size;
    idx        = handle_q[XW-1:0];
    hgen       = handle_q[gha_pkg::HANDLE_W-1:XW];
    in_range   = (MW'(idx) < MW'(n_cnt));
    seen       = (idx < XW'(fresh_next));
    eff_free   = !seen || st_rd.free;
    remaining  = fresh_next - allocated_total;
    fresh_ext  = PW'(fresh_next);
    fresh_slot = fresh_ext[IW-1:0];

    have    = 1'b0;
    slot    = recycled_head;
    cur_gen = st_rd.gen;
    fresh_next_next      = fresh_next;
    allocated_total_next = allocated_total;
    recycled_head_next   = recycled_head;
    recycled_valid_next  = recycled_valid;
    st_we    = 1'b0;
    st_waddr = recycled_head;
    st_wdata = st_rd;
    link_we  = 1'b0;
    status_next     = 1'b1;
    handle_out_next = '0;
    slot_index_next = '0;

    // Pop the recycled list first, then the never-used slots.
    if (recycled_valid) begin
      have = 1'b1;
    end else if (fresh_next < n_cnt) begin
      have    = 1'b1;
      slot    = fresh_slot;
      cur_gen = '0;
    end
    new_gen = cur_gen + GW'(1);
    if (new_gen == '0) new_gen = GW'(1);

    slot_ext = 32'(slot);
    idx_ext  = 32'(idx);
    free_ok  = (handle_q != '0) && in_range && !eff_free;
    look_ok  = free_ok && (st_rd.gen == hgen);

    if (cmd.exec) begin
      unique case (op_q)
        gha_pkg::OP_ALLOC: begin
          if (have) begin
            if (recycled_valid) begin
              if (remaining > CW'(1)) begin
                recycled_head_next = link_rd;
              end else begin
                recycled_valid_next = 1'b0;
                recycled_head_next  = '0;
              end
            end else begin
              fresh_next_next = fresh_next + CW'(1);
            end
            st_we                = 1'b1;
            st_waddr             = slot;
            st_wdata.free        = 1'b0;
            st_wdata.gen         = new_gen;
            allocated_total_next = allocated_total + CW'(1);
            status_next          = 1'b0;
            handle_out_next      = {new_gen, XW'(slot)};
            slot_index_next      = slot_ext[gha_pkg::SIDX_W-1:0];
          end
        end
        gha_pkg::OP_FREE: begin
          if (free_ok) begin
            st_we                = 1'b1;
            st_waddr             = idx[IW-1:0];
            st_wdata.free        = 1'b1;
            st_wdata.gen         = st_rd.gen;
            link_we              = 1'b1;
            recycled_head_next   = idx[IW-1:0];
            recycled_valid_next  = 1'b1;
            allocated_total_next = allocated_total - CW'(1);
            status_next          = 1'b0;
          end
        end
        gha_pkg::OP_LOOKUP: begin
          if (look_ok) begin
            status_next     = 1'b0;
            slot_index_next = idx_ext[gha_pkg::SIDX_W-1:0];
          end
        end
        default: begin
          status_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size       <= gha_pkg::POOL_SIZE_RESET;
      fresh_next      <= '0;
      allocated_total <= '0;
      recycled_head   <= '0;
      recycled_valid  <= 1'b0;
      rsp_valid       <= 1'b0;
    end else begin
      if (cmd.cfg_write) begin
        // Reinitialize the pool along with the new count.
        pool_size       <= cfg_pool_size;
        fresh_next      <= '0;
        allocated_total <= '0;
        recycled_head   <= '0;
        recycled_valid  <= 1'b0;
      end else begin
        fresh_next      <= fresh_next_next;
        allocated_total <= allocated_total_next;
        recycled_head   <= recycled_head_next;
        recycled_valid  <= recycled_valid_next;
      end
      if (cmd.exec) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp_status     <= status_next;
      rsp_handle_out <= handle_out_next;
      rsp_slot_index <= slot_index_next;
      rsp_live_count <= allocated_total_next;
    end
  end

  a_total_le_fresh: assert property (@(posedge clk) disable iff (rst)
    allocated_total <= fresh_next)
    else $error("more slots taken than ever handed out");

  a_fresh_le_count: assert property (@(posedge clk) disable iff (rst)
    fresh_next <= n_cnt)
    else $error("fresh-slot counter ran past the pool size");

  a_list_matches_count: assert property (@(posedge clk) disable iff (rst)
    recycled_valid == (fresh_next != allocated_total))
    else $error("recycled list state disagrees with the slot counts");

  a_exec_loads_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> rsp_valid)
    else $error("executed operation left no result beat");

endmodule

[hw/rtl/generational_handle_allocator.sv]
// Top level of the generational handle allocator.
// Depends on gha_pkg, the three channel interfaces, gha_ctrl and gha_datapath.
//
// Usage:
//   req carries one operation per beat: opcode (allocate, free, lookup) and
//   a 32-bit handle (slot index in bits 15:0, generation in bits 31:16).
//   rsp returns exactly one beat per request: status, the new handle on a
//   successful allocate, the slot index and the live slot count.
//   cfg writes the pool size; the write also empties the pool as reset does.
// Timing:
//   A request beat moves the sequencer to execute, which loads its response into
//   the output register; no new request is taken until then. The slot tables are
//   read in the accept cycle and updated in the execute cycle, one memory access
//   each. The response sits in an output register, so the next request is taken
//   while it waits; execute holds only if that register is still full.
// Reset:
//   rst (synchronous) sets the pool size to 1024 and empties the pool at once;
//   the tables need no clearing pass, since unused slots read as free.
//   A cfg beat in the same cycle as a request beat is taken first.
`timescale 1ns / 1ps

module generational_handle_allocator #(
  parameter int MAX_BLOCKS = gha_pkg::MAX_BLOCKS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  gha_req_if.sink    req,
  gha_rsp_if.source  rsp,
  gha_cfg_if.sink    cfg
);

  gha_pkg::cmd_t cmd;
  gha_pkg::sts_t sts;

  gha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .cfg_valid (cfg.valid),
    .sts       (sts),
    .req_ready (req.ready),
    .cfg_ready (cfg.ready),
    .cmd       (cmd)
  );

  gha_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .req_opcode      (req.opcode),
    .req_handle_in   (req.handle_in),
    .cfg_pool_size   (cfg.pool_size),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_handle_out  (rsp.handle_out),
    .rsp_slot_index  (rsp.slot_index),
    .rsp_live_count  (rsp.live_count)
  );

endmodule

[verif/tb_generational_handle_allocator.sv]
// Testbench for generational_handle_allocator: directed corner cases, a short
// generation climb on one slot and random allocate/free/lookup traffic under back-pressure.
// Depends on gha_pkg, gha_req_if, gha_rsp_if, gha_cfg_if and the RTL top level.
`timescale 1ns / 1ps

typedef struct {
  logic                         status;
  logic [gha_pkg::HANDLE_W-1:0] handle;
  logic [gha_pkg::SIDX_W-1:0]   slot;
  logic [gha_pkg::CNT_W-1:0]    live;
} pool_reply_t;

// Shadow copy of the slot pool; predicts one reply per request beat.
class pool_shadow;
  logic [gha_pkg::GEN_W-1:0]  gen_tab  [gha_pkg::MAX_BLOCKS_DEFAULT];
  bit                         free_tab [gha_pkg::MAX_BLOCKS_DEFAULT];
  logic [gha_pkg::SIDX_W-1:0] link_tab [gha_pkg::MAX_BLOCKS_DEFAULT];
  int unsigned recycled_head;
  bit          recycled_any;
  int unsigned fresh_next;
  int unsigned live_total;
  int unsigned pool_size;
  pool_reply_t pending_replies[$];
  int mismatches;
  int replies;
  int refused;
  int op_beats[4];

  function new();
    mismatches = 0;
    replies = 0;
    refused = 0;
    foreach (op_beats[i]) op_beats[i] = 0;
    set_pool_size(gha_pkg::POOL_SIZE_RESET);
  endfunction

  // A pool size write empties the pool just as reset does.
  function void set_pool_size(int unsigned value);
    pool_size = value;
    foreach (gen_tab[i]) begin
      gen_tab[i] = '0;
      free_tab[i] = 1'b1;
      link_tab[i] = '0;
    end
    recycled_head = 0;
    recycled_any = 1'b0;
    fresh_next = 0;
    live_total = 0;
  endfunction

  function int unsigned slots();
    return (pool_size > gha_pkg::MAX_BLOCKS_DEFAULT) ?
           gha_pkg::MAX_BLOCKS_DEFAULT : pool_size;
  endfunction

  function void note_request(logic [gha_pkg::OP_W-1:0] op,
                             logic [gha_pkg::HANDLE_W-1:0] h);
    pool_reply_t r;
    int unsigned n;
    int unsigned idx;
    int unsigned slot;
    logic [gha_pkg::GEN_W-1:0] g;
    bit have;
    n = slots();
    idx = h[15:0];
    r.status = 1'b1;
    r.handle = '0;
    r.slot = '0;
    op_beats[op]++;
    case (op)
      gha_pkg::OP_ALLOC: begin
        have = 1'b1;
        slot = 0;
        if (recycled_any) begin
          // recycled entries are the slots below fresh_next that are not taken
          slot = recycled_head;
          if (fresh_next - live_total > 1) begin
            recycled_head = link_tab[slot];
          end else begin
            recycled_any = 1'b0;
            recycled_head = 0;
          end
        end else if (fresh_next < n) begin
          slot = fresh_next;
          fresh_next++;
        end else begin
          have = 1'b0;
        end
        if (have) begin
          g = gen_tab[slot] + 1'b1;
          if (g == '0) g = 1;
          gen_tab[slot] = g;
          free_tab[slot] = 1'b0;
          live_total++;
          r.status = 1'b0;
          r.handle = {g, 16'(slot)};
          r.slot = 10'(slot);
        end
      end
      gha_pkg::OP_FREE: begin
        if (h != '0 && idx < n && !free_tab[idx]) begin
          free_tab[idx] = 1'b1;
          live_total--;
          link_tab[idx] = 10'(recycled_head);
          recycled_head = idx;
          recycled_any = 1'b1;
          r.status = 1'b0;
        end
      end
      gha_pkg::OP_LOOKUP: begin
        if (h != '0 && idx < n && !free_tab[idx] && gen_tab[idx] == h[31:16]) begin
          r.status = 1'b0;
          r.slot = 10'(idx);
        end
      end
      default: ;
    endcase
    r.live = 11'(live_total);
    pending_replies.push_back(r);
  endfunction

  task report_mismatch(string what);
    $display("%0t ERROR %s", $time, what);
    mismatches++;
  endtask

  task check_reply(pool_reply_t got);
    pool_reply_t want;
    replies++;
    if (got.status) refused++;
    if (pending_replies.size() == 0) begin
      report_mismatch($sformatf("reply %0d with nothing pending: status %0d handle %h",
                                replies, got.status, got.handle));
      return;
    end
    want = pending_replies.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("reply %0d status %0d, want %0d",
                                replies, got.status, want.status));
    if (got.handle !== want.handle)
      report_mismatch($sformatf("reply %0d handle_out %h, want %h",
                                replies, got.handle, want.handle));
    if (got.slot !== want.slot)
      report_mismatch($sformatf("reply %0d slot_index %0d, want %0d",
                                replies, got.slot, want.slot));
    if (got.live !== want.live)
      report_mismatch($sformatf("reply %0d live_count %0d, want %0d",
                                replies, got.live, want.live));
  endtask

  // Current handle of some taken slot, or 0 when none is taken.
  function logic [gha_pkg::HANDLE_W-1:0] pick_live_handle();
    int unsigned n;
    int unsigned start;
    int unsigned idx;
    n = slots();
    if (live_total == 0 || n == 0) return '0;
    start = $urandom_range(0, n - 1);
    for (int unsigned k = 0; k < n; k++) begin
      idx = (start + k) % n;
      if (!free_tab[idx]) return {gen_tab[idx], 16'(idx)};
    end
    return '0;
  endfunction

  // Some free slot in range; the count itself when all are taken.
  function int unsigned pick_free_index();
    int unsigned n;
    int unsigned start;
    int unsigned idx;
    n = slots();
    if (n == 0) return 0;
    start = $urandom_range(0, n - 1);
    for (int unsigned k = 0; k < n; k++) begin
      idx = (start + k) % n;
      if (free_tab[idx]) return idx;
    end
    return n;
  endfunction
endclass

module tb_generational_handle_allocator;

  localparam logic [gha_pkg::OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PHASE_ITEMS = 216;
  localparam int SLOT_ROUNDS = 32;

  logic clk;
  logic rst;

  gha_req_if req ();
  gha_rsp_if rsp ();
  gha_cfg_if cfg ();

  generational_handle_allocator u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  pool_shadow pool;
  int req_gap_max;
  int rsp_gap_max;
  int rsp_hold_cycles;
  int cycles = 0;
  int cfg_writes = 0;
  int phase_count [8] = '{3, 64, 1024, 17, 1025, 200, 2047, 1};
  int phase_alloc [8] = '{50, 60, 45, 70, 55, 80, 40, 50};

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Watch all three channels; every beat is sampled before the edge updates it.
  always @(posedge clk) begin
    pool_reply_t got;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        got.status = rsp.status;
        got.handle = rsp.handle_out;
        got.slot = rsp.slot_index;
        got.live = rsp.live_count;
        pool.check_reply(got);
      end
      if (cfg.valid && cfg.ready) pool.set_pool_size(cfg.pool_size);
      if (req.valid && req.ready) pool.note_request(req.opcode, req.handle_in);
    end
  end

  // Reply side: random stalls per beat, plus one long hold-off on request.
  initial begin
    int gap;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rsp_hold_cycles > 0) begin
        rsp.ready <= 1'b0;
        repeat (rsp_hold_cycles) @(posedge clk);
        rsp_hold_cycles = 0;
      end else begin
        gap = $urandom_range(0, rsp_gap_max);
        if (gap > 0) begin
          rsp.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!(rsp.valid && rsp.ready)) @(posedge clk);
    end
  end

  // Leaves valid high on return so a back-to-back beat needs no extra edge.
  task automatic send_req(logic [gha_pkg::OP_W-1:0] op, logic [gha_pkg::HANDLE_W-1:0] h);
    int gap;
    gap = $urandom_range(0, req_gap_max);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.opcode <= op;
    req.handle_in <= h;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pool.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pool_size(logic [gha_pkg::CNT_W-1:0] value);
    wait_idle();
    cfg.valid <= 1'b1;
    cfg.pool_size <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic send_random_item(int alloc_pct);
    int pick;
    int kind;
    int unsigned n;
    logic [gha_pkg::OP_W-1:0] op;
    logic [gha_pkg::HANDLE_W-1:0] h;
    n = pool.slots();
    pick = $urandom_range(0, 99);
    op = gha_pkg::OP_ALLOC;
    h = $urandom;
    if (pick < alloc_pct) begin
      op = gha_pkg::OP_ALLOC;
    end else if (pick < alloc_pct + (100 - alloc_pct) / 2) begin
      h = pool.pick_live_handle();
      if (h != '0) begin
        op = ($urandom_range(0, 1) == 0) ? gha_pkg::OP_FREE : gha_pkg::OP_LOOKUP;
        // skew the generation now and then: free ignores it, lookup must refuse
        if ($urandom_range(0, 3) == 0) h[31:16] = h[31:16] ^ 16'($urandom_range(1, 65535));
      end else begin
        h = $urandom;
      end
    end else begin
      kind = $urandom_range(0, 4);
      op = ($urandom_range(0, 1) == 0) ? gha_pkg::OP_FREE : gha_pkg::OP_LOOKUP;
      case (kind)
        0: begin
          op = 2'($urandom);
          h = $urandom;
        end
        1: h = '0;
        2: h = {16'($urandom), 16'($urandom_range(n, 65535))};
        3: h = {16'($urandom), 16'(pool.pick_free_index())};
        default: op = OP_RESERVED;
      endcase
    end
    send_req(op, h);
  endtask

  initial begin
    logic [gha_pkg::GEN_W-1:0] wrap_gen;
    pool = new();
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.opcode <= gha_pkg::OP_ALLOC;
    req.handle_in <= '0;
    cfg.valid <= 1'b0;
    cfg.pool_size <= gha_pkg::POOL_SIZE_RESET;
    req_gap_max = 16;
    rsp_gap_max = 16;
    rsp_hold_cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Corner cases at the reset count.
    send_req(gha_pkg::OP_LOOKUP, 32'h0000_0000);
    send_req(gha_pkg::OP_FREE, 32'h0000_0000);
    send_req(OP_RESERVED, 32'hFFFF_FFFF);
    send_req(gha_pkg::OP_LOOKUP, 32'h0001_0000);
    send_req(gha_pkg::OP_FREE, 32'h0001_0005);
    send_req(gha_pkg::OP_ALLOC, 32'hFFFF_FFFF);
    send_req(gha_pkg::OP_ALLOC, 32'h0000_0000);
    send_req(gha_pkg::OP_LOOKUP, 32'h0001_0000);
    send_req(gha_pkg::OP_LOOKUP, 32'h0002_0001);
    send_req(gha_pkg::OP_FREE, 32'hFFFF_0001);
    send_req(gha_pkg::OP_FREE, 32'h0001_0001);
    send_req(gha_pkg::OP_LOOKUP, 32'h0001_0400);
    send_req(gha_pkg::OP_FREE, 32'hFFFF_FFFF);
    send_req(gha_pkg::OP_ALLOC, 32'h0000_0000);
    send_req(gha_pkg::OP_ALLOC, 32'h0000_0000);

    // One slot: empty pool, then no slots at all, then a clamped count.
    write_pool_size(11'd1);
    send_req(gha_pkg::OP_ALLOC, 32'h0000_0000);
    send_req(gha_pkg::OP_ALLOC, 32'h0000_0000);
    send_req(gha_pkg::OP_LOOKUP, 32'h0001_0001);
    send_req(gha_pkg::OP_FREE, 32'h0001_0000);
    send_req(gha_pkg::OP_FREE, 32'h0001_0000);
    write_pool_size(11'd0);
    send_req(gha_pkg::OP_ALLOC, 32'h0000_0000);
    send_req(gha_pkg::OP_LOOKUP, 32'h0001_0000);
    send_req(gha_pkg::OP_FREE, 32'h0001_0000);
    write_pool_size(11'd2047);
    send_req(gha_pkg::OP_LOOKUP, 32'h0001_03FF);
    send_req(gha_pkg::OP_ALLOC, 32'h0000_0000);
    send_req(gha_pkg::OP_LOOKUP, 32'h0001_0400);

    // Cycle slot 0 back to back so its generation climbs on every allocate.
    write_pool_size(11'd1);
    req_gap_max = 0;
    rsp_gap_max = 0;
    wrap_gen = '0;
    for (int i = 0; i < SLOT_ROUNDS; i++) begin
      send_req(gha_pkg::OP_ALLOC, $urandom);
      wrap_gen = (wrap_gen == 16'hFFFF) ? 16'd1 : wrap_gen + 16'd1;
      if (i % 8 == 0 || i >= SLOT_ROUNDS - 3)
        send_req(gha_pkg::OP_LOOKUP, {wrap_gen, 16'h0000});
      send_req(gha_pkg::OP_FREE, {16'($urandom_range(1, 65535)), 16'h0000});
    end

    for (int p = 0; p < 8; p++) begin
      write_pool_size(11'(phase_count[p]));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
        if (i % 48 == 0) rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
        if (p == 2 && i == 100) begin
          // stall replies long enough to back up the request side, then drain
          rsp_hold_cycles = 300;
          req_gap_max = 0;
          repeat (24) send_random_item(phase_alloc[p]);
          wait_idle();
        end
        send_random_item(phase_alloc[p]);
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (pool.pending_replies.size() != 0)
      pool.report_mismatch($sformatf("%0d replies never arrived",
                                     pool.pending_replies.size()));
    $display("covered %0d request beats: alloc %0d, free %0d, lookup %0d, unused op %0d",
             pool.op_beats[0] + pool.op_beats[1] + pool.op_beats[2] + pool.op_beats[3],
             pool.op_beats[0], pool.op_beats[1], pool.op_beats[2], pool.op_beats[3]);
    $display("%0d replies (%0d refused), %0d pool size writes, %0d rounds on slot 0",
             pool.replies, pool.refused, cfg_writes, SLOT_ROUNDS);
    if (pool.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
